FILE: design/sldx_pkg.sv
package sldx_pkg;

  localparam int MAX_FRAME = 256;
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int LEN_W = 16;
  localparam int HEAD_N = 4;
  localparam int ACK_N = 9;
  localparam int ACK_IDX_W = $clog2(ACK_N);

  localparam logic [7:0] SYNC_BYTE = 8'hFE;
  localparam logic [7:0] ACK_LEN_HI = 8'h00;
  localparam logic [7:0] ACK_LEN_LO = 8'h05;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  localparam logic [ACK_IDX_W-1:0] ACK_SYNC0 = ACK_IDX_W'(0);
  localparam logic [ACK_IDX_W-1:0] ACK_SYNC1 = ACK_IDX_W'(1);
  localparam logic [ACK_IDX_W-1:0] ACK_LENH = ACK_IDX_W'(2);
  localparam logic [ACK_IDX_W-1:0] ACK_LENL = ACK_IDX_W'(3);
  localparam logic [ACK_IDX_W-1:0] ACK_H0 = ACK_IDX_W'(4);
  localparam logic [ACK_IDX_W-1:0] ACK_H1 = ACK_IDX_W'(5);
  localparam logic [ACK_IDX_W-1:0] ACK_H2 = ACK_IDX_W'(6);
  localparam logic [ACK_IDX_W-1:0] ACK_H3 = ACK_IDX_W'(7);
  localparam logic [ACK_IDX_W-1:0] ACK_SUM = ACK_IDX_W'(ACK_N - 1);

  typedef enum logic [1:0] {
    ST_ONGOING = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BAD     = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SYNC1   = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 valid;
    logic [7:0]           data;
    logic [7:0]           index;
    logic                 frame_end;
    status_t              status;
    logic                 ack;
    logic [HEAD_N-1:0][7:0] head;
  } result_t;

endpackage

FILE: design/sldx_parser.sv
module sldx_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output sldx_pkg::result_t   res
);

  sldx_pkg::phase_t                 phase, phase_next;
  logic [sldx_pkg::CNT_W-1:0]       count, count_next, count_inc;
  logic [sldx_pkg::LEN_W-1:0]       frame_len, frame_len_next;
  logic [7:0]                       check, check_next;
  logic [sldx_pkg::HEAD_N-1:0][7:0] head, head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= sldx_pkg::PH_SYNC1;
      count     <= '0;
      frame_len <= '0;
      check     <= '0;
      head      <= '0;
    end else begin
      phase     <= phase_next;
      count     <= count_next;
      frame_len <= frame_len_next;
      check     <= check_next;
      head      <= head_next;
    end
  end

  assign count_inc = count + sldx_pkg::CNT_W'(1);

  always_comb begin
    phase_next     = phase;
    count_next     = count;
    frame_len_next = frame_len;
    check_next     = check;
    head_next      = head;
    res            = '0;
    res.status     = sldx_pkg::ST_ONGOING;
    if (accept) begin
      unique case (phase)
        sldx_pkg::PH_PAYLOAD: begin
          if (count < sldx_pkg::CNT_W'(sldx_pkg::HEAD_N)) begin
            head_next[count[1:0]] = rx_byte;
          end
          check_next = check ^ rx_byte;
          res.valid  = 1'b1;
          res.data   = rx_byte;
          res.index  = 8'(count);
          if (frame_len <= sldx_pkg::LEN_W'(count_inc)) begin
            phase_next    = sldx_pkg::PH_SYNC1;
            count_next    = '0;
            res.frame_end = 1'b1;
            if (check_next == 8'd0) begin
              res.status = sldx_pkg::ST_GOOD;
              res.ack    = 1'b1;
            end else begin
              res.status = sldx_pkg::ST_BAD;
            end
          end else if (count_inc >= sldx_pkg::CNT_W'(sldx_pkg::MAX_FRAME)) begin
            phase_next     = sldx_pkg::PH_SYNC1;
            count_next     = '0;
            frame_len_next = '0;
            res.frame_end  = 1'b1;
            res.status     = sldx_pkg::ST_ABORT;
          end else begin
            count_next = count_inc;
          end
        end
        sldx_pkg::PH_LENGTH: begin
          frame_len_next = {frame_len[7:0], rx_byte};
          if (count != '0) begin
            head_next  = '0;
            check_next = '0;
            count_next = '0;
            phase_next = sldx_pkg::PH_PAYLOAD;
          end else begin
            count_next = count_inc;
          end
        end
        sldx_pkg::PH_SYNC2: begin
          if (rx_byte == sldx_pkg::SYNC_BYTE) begin
            frame_len_next = '0;
            count_next     = '0;
            phase_next     = sldx_pkg::PH_LENGTH;
          end else begin
            phase_next = sldx_pkg::PH_SYNC1;
          end
        end
        sldx_pkg::PH_SYNC1: begin
          if (rx_byte == sldx_pkg::SYNC_BYTE) begin
            phase_next = sldx_pkg::PH_SYNC2;
          end else begin
            phase_next = sldx_pkg::PH_SYNC1;
          end
        end
        default: begin
          phase_next = sldx_pkg::PH_SYNC1;
        end
      endcase
    end
    res.head = head_next;
  end

endmodule

FILE: design/sldx_out.sv
module sldx_out (
  input  logic              clk,
  input  logic              rst,
  input  sldx_pkg::result_t res,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_data,
  output logic [7:0]        out_index,
  output logic              out_end,
  output logic [1:0]        out_status,
  output logic              out_last
);

  logic                            load;
  logic                            ack_active;
  logic [sldx_pkg::ACK_IDX_W-1:0]  ack_idx;
  logic [sldx_pkg::HEAD_N-1:0][7:0] ack_head;
  logic [7:0]                      ack_sum;
  logic [7:0]                      ack_byte;
  logic [7:0]                      h0_inc;

  assign load     = !out_valid || out_ready;
  assign in_ready = !rst && !ack_active && load;
  assign h0_inc   = res.head[0] + 8'd1;

  always_comb begin
    unique case (ack_idx)
      sldx_pkg::ACK_SYNC0: ack_byte = sldx_pkg::SYNC_BYTE;
      sldx_pkg::ACK_SYNC1: ack_byte = sldx_pkg::SYNC_BYTE;
      sldx_pkg::ACK_LENH:  ack_byte = sldx_pkg::ACK_LEN_HI;
      sldx_pkg::ACK_LENL:  ack_byte = sldx_pkg::ACK_LEN_LO;
      sldx_pkg::ACK_H0:    ack_byte = ack_head[0];
      sldx_pkg::ACK_H1:    ack_byte = ack_head[1];
      sldx_pkg::ACK_H2:    ack_byte = ack_head[2];
      sldx_pkg::ACK_H3:    ack_byte = ack_head[3];
      sldx_pkg::ACK_SUM:   ack_byte = ack_sum;
      default:             ack_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      ack_active <= 1'b0;
      ack_idx    <= '0;
    end else if (load) begin
      if (ack_active) begin
        out_valid <= 1'b1;
        ack_idx   <= ack_idx + sldx_pkg::ACK_IDX_W'(1);
        if (ack_idx == sldx_pkg::ACK_SUM) begin
          ack_active <= 1'b0;
        end
      end else if (res.valid) begin
        out_valid  <= 1'b1;
        ack_active <= res.ack;
        ack_idx    <= '0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the result register and captured acknowledge bytes
  always_ff @(posedge clk) begin
    if (load) begin
      if (ack_active) begin
        out_kind   <= sldx_pkg::KIND_ACK;
        out_data   <= ack_byte;
        out_index  <= 8'(ack_idx);
        out_end    <= 1'b0;
        out_status <= sldx_pkg::ST_ONGOING;
        out_last   <= (ack_idx == sldx_pkg::ACK_SUM);
      end else if (res.valid) begin
        out_kind   <= sldx_pkg::KIND_PAYLOAD;
        out_data   <= res.data;
        out_index  <= res.index;
        out_end    <= res.frame_end;
        out_status <= res.status;
        out_last   <= !res.ack;
        if (res.ack) begin
          ack_head[0] <= h0_inc;
          ack_head[1] <= res.head[1];
          ack_head[2] <= res.head[2];
          ack_head[3] <= res.head[3];
          ack_sum     <= h0_inc ^ res.head[1] ^ res.head[2] ^ res.head[3];
        end
      end
    end
  end

endmodule

FILE: design/sync_length_xor_deframer.sv
// Byte-stream deframer. Hunts for the sync pair FE FE, reads a two-byte
// big-endian length (0 counts as 1) and passes each payload byte on with its
// index, flagging the last byte with a good or check-failed status from the
// running XOR, or an abort status once MAX_FRAME bytes arrive without the
// frame ending. One input byte is taken per cycle while the output register
// can load and no acknowledge is being sent; each payload byte leaves through
// a single output register in the cycle after it is taken. After a good frame
// the block emits a nine-byte acknowledge (FE FE 00 05, first payload byte
// plus one, payload bytes two to four, their XOR) with s_tready held low.
module sync_length_xor_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                 // [16] frame_end, [18:17] frame_status, [23:19] zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast    // last
);

  logic              accept;
  sldx_pkg::result_t res;
  logic [7:0]        out_data;
  logic [7:0]        out_index;
  logic              out_end;
  logic [1:0]        out_status;

  assign accept = s_tvalid && s_tready;

  sldx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .res     (res)
  );

  sldx_out u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_data   (out_data),
    .out_index  (out_index),
    .out_end    (out_end),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'd0, out_status, out_end, out_index, out_data};

endmodule
